@@ src/chpp_pkg.sv @@
// shared types and constants of the colon header packet parser
`timescale 1ns / 1ps

package chpp_pkg;

    localparam int MAX_DATA   = 1024;
    localparam int NAME_MAX   = 255;

    localparam int BYTE_W     = 8;
    localparam int NUM_W      = 32;
    localparam int SIZE_W     = 11;
    localparam int NAME_CNT_W = $clog2(NAME_MAX + 1);
    localparam int KIND_W     = 2;
    localparam int PROD_W     = NUM_W + 4;

    // output tdata layout, packed from the lowest bit up
    localparam int OUT_BITS   = BYTE_W + NUM_W + NUM_W + SIZE_W + 1;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [BYTE_W-1:0] COLON  = 8'h3a;
    localparam logic [BYTE_W-1:0] CHAR_0 = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_9 = 8'h39;

    localparam logic [KIND_W-1:0] KIND_HEADER = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NAME   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DATA   = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              first;
    } t_item;

endpackage

@@ src/chpp_in_stage.sv @@
// input register stage of the parser
`timescale 1ns / 1ps

module chpp_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  chpp_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output chpp_pkg::t_item o_item
);

    logic            r_valid;
    chpp_pkg::t_item r_item;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

@@ src/chpp_core.sv @@
// parser state, field decoding and result register
`timescale 1ns / 1ps

module chpp_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  chpp_pkg::t_item                     i_item,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [chpp_pkg::KIND_W-1:0]         o_kind,
    output logic [chpp_pkg::BYTE_W-1:0]         o_byte_value,
    output logic [chpp_pkg::NUM_W-1:0]          o_total_frags,
    output logic [chpp_pkg::NUM_W-1:0]          o_fragment_number,
    output logic [chpp_pkg::SIZE_W-1:0]         o_data_size,
    output logic                                o_final_fragment,
    output logic                                o_last
);

    typedef enum logic [2:0] {
        PH_IDLE, PH_TOTAL, PH_FRAG, PH_SIZE, PH_NAME, PH_DATA, PH_DONE
    } t_phase;

    t_phase                              r_phase, n_phase, s_phase;
    logic [chpp_pkg::NUM_W-1:0]          r_total, n_total, s_total;
    logic [chpp_pkg::NUM_W-1:0]          r_frag, n_frag, s_frag;
    logic [chpp_pkg::SIZE_W-1:0]         r_size, n_size, s_size;
    logic                                r_ended, n_ended, s_ended;
    logic [chpp_pkg::NAME_CNT_W-1:0]     r_name_cnt, n_name_cnt, s_name_cnt;
    logic [chpp_pkg::SIZE_W-1:0]         r_remain, n_remain, s_remain;

    logic                                r_out_valid;
    logic [chpp_pkg::KIND_W-1:0]         r_kind, n_kind;
    logic [chpp_pkg::BYTE_W-1:0]         r_byte, n_byte;
    logic [chpp_pkg::NUM_W-1:0]          r_o_total, n_o_total;
    logic [chpp_pkg::NUM_W-1:0]          r_o_frag, n_o_frag;
    logic [chpp_pkg::SIZE_W-1:0]         r_o_size, n_o_size;
    logic                                r_fin, n_fin;
    logic                                r_last, n_last;
    logic                                n_has_result;

    logic [chpp_pkg::BYTE_W-1:0]         b;
    logic                                is_digit;
    logic [3:0]                          digit;
    logic [chpp_pkg::NUM_W-1:0]          acc_sel;
    logic [chpp_pkg::PROD_W-1:0]         prod;
    logic [chpp_pkg::NUM_W-1:0]          num_sat;
    logic [chpp_pkg::SIZE_W-1:0]         size_sat;
    logic [chpp_pkg::SIZE_W-1:0]         remain_dec;
    logic                                advance;

    localparam logic [chpp_pkg::PROD_W-1:0] SizeLimit = chpp_pkg::PROD_W'(chpp_pkg::MAX_DATA);

    assign advance = !r_out_valid || i_ready;
    assign o_ready = advance;

    assign b        = i_item.data_byte;
    assign is_digit = (b >= chpp_pkg::CHAR_0) && (b <= chpp_pkg::CHAR_9);
    assign digit    = 4'(b - chpp_pkg::CHAR_0);

    // a first item restarts the parse on that very byte
    always_comb begin
        if (i_item.first) begin
            s_phase    = PH_TOTAL;
            s_total    = '0;
            s_frag     = '0;
            s_size     = '0;
            s_ended    = 1'b0;
            s_name_cnt = '0;
            s_remain   = '0;
        end else begin
            s_phase    = r_phase;
            s_total    = r_total;
            s_frag     = r_frag;
            s_size     = r_size;
            s_ended    = r_ended;
            s_name_cnt = r_name_cnt;
            s_remain   = r_remain;
        end
    end

    // one shared times-ten unit serves whichever number field is open
    always_comb begin
        unique case (s_phase)
            PH_TOTAL: acc_sel = s_total;
            PH_FRAG:  acc_sel = s_frag;
            default:  acc_sel = chpp_pkg::NUM_W'(s_size);
        endcase
        prod     = {1'b0, acc_sel, 3'b000} + {3'b000, acc_sel, 1'b0}
                   + chpp_pkg::PROD_W'(digit);
        num_sat  = (prod[chpp_pkg::PROD_W-1:chpp_pkg::NUM_W] != '0) ? '1
                                                                    : prod[chpp_pkg::NUM_W-1:0];
        size_sat = (prod > SizeLimit) ? chpp_pkg::SIZE_W'(chpp_pkg::MAX_DATA)
                                      : prod[chpp_pkg::SIZE_W-1:0];
        remain_dec = (s_remain != '0) ? s_remain - chpp_pkg::SIZE_W'(1) : s_remain;
    end

    always_comb begin
        n_phase      = s_phase;
        n_total      = s_total;
        n_frag       = s_frag;
        n_size       = s_size;
        n_ended      = s_ended;
        n_name_cnt   = s_name_cnt;
        n_remain     = s_remain;
        n_has_result = 1'b0;
        n_kind       = chpp_pkg::KIND_HEADER;
        n_byte       = '0;
        n_o_total    = '0;
        n_o_frag     = '0;
        n_o_size     = '0;
        n_fin        = 1'b0;
        n_last       = 1'b0;
        unique case (s_phase)
            PH_TOTAL, PH_FRAG, PH_SIZE: begin
                if (b == chpp_pkg::COLON) begin
                    n_ended = 1'b0;
                    n_phase = t_phase'(s_phase + 3'd1);
                end else if (is_digit) begin
                    if (!s_ended) begin
                        unique case (s_phase)
                            PH_TOTAL: n_total = num_sat;
                            PH_FRAG:  n_frag  = num_sat;
                            default:  n_size  = size_sat;
                        endcase
                    end
                end else begin
                    n_ended = 1'b1;
                end
            end
            PH_NAME: begin
                if (b == chpp_pkg::COLON) begin
                    n_has_result = 1'b1;
                    n_kind       = chpp_pkg::KIND_HEADER;
                    n_o_total    = s_total;
                    n_o_frag     = s_frag;
                    n_o_size     = s_size;
                    n_fin        = (s_frag == s_total);
                    n_last       = (s_size == '0);
                    n_remain     = s_size;
                    n_phase      = (s_size == '0) ? PH_DONE : PH_DATA;
                end else if (s_name_cnt < chpp_pkg::NAME_CNT_W'(chpp_pkg::NAME_MAX)) begin
                    n_name_cnt   = s_name_cnt + chpp_pkg::NAME_CNT_W'(1);
                    n_has_result = 1'b1;
                    n_kind       = chpp_pkg::KIND_NAME;
                    n_byte       = b;
                end
            end
            PH_DATA: begin
                n_remain     = remain_dec;
                n_has_result = 1'b1;
                n_kind       = chpp_pkg::KIND_DATA;
                n_byte       = b;
                n_last       = (remain_dec == '0);
                if (remain_dec == '0) begin
                    n_phase = PH_DONE;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_total     <= '0;
            r_frag      <= '0;
            r_size      <= '0;
            r_ended     <= 1'b0;
            r_name_cnt  <= '0;
            r_remain    <= '0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= i_valid && n_has_result;
            if (i_valid) begin
                r_phase    <= n_phase;
                r_total    <= n_total;
                r_frag     <= n_frag;
                r_size     <= n_size;
                r_ended    <= n_ended;
                r_name_cnt <= n_name_cnt;
                r_remain   <= n_remain;
            end
        end
        if (advance && i_valid && n_has_result) begin
            r_kind    <= n_kind;
            r_byte    <= n_byte;
            r_o_total <= n_o_total;
            r_o_frag  <= n_o_frag;
            r_o_size  <= n_o_size;
            r_fin     <= n_fin;
            r_last    <= n_last;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_kind            = r_kind;
    assign o_byte_value      = r_byte;
    assign o_total_frags     = r_o_total;
    assign o_fragment_number = r_o_frag;
    assign o_data_size       = r_o_size;
    assign o_final_fragment  = r_fin;
    assign o_last            = r_last;

`ifndef SYNTHESIS
    // the data phase is only ever entered with bytes still owed
    a_data_owed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DATA |-> r_remain != '0)
        else $error("data phase with nothing remaining");

    // a header that closes the message must carry a zero size
    a_hdr_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind == chpp_pkg::KIND_HEADER && r_last) |-> r_o_size == '0)
        else $error("header flagged last with nonzero size");

    // byte items carry no header numbers
    a_byte_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind != chpp_pkg::KIND_HEADER)
        |-> (r_o_total == '0 && r_o_frag == '0 && r_o_size == '0 && !r_fin))
        else $error("byte item carries header fields");

    // size never exceeds the cap
    a_size_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_size <= chpp_pkg::SIZE_W'(chpp_pkg::MAX_DATA))
        else $error("size above cap");
`endif

endmodule

@@ src/colon_header_packet_parser_unit.sv @@
// colon header packet parser: top level
// an accepted item's result is held first in the input register, then in the core result register
// throughput: one byte item per cycle while the output is not stalled, set by the
// single-pass decode between the input register and the result register
// reset: synchronous active-low i_rst_n clears the phase, counters and valids;
// after reset the parser ignores bytes until one arrives with the first flag
`timescale 1ns / 1ps

module colon_header_packet_parser_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  logic [chpp_pkg::BYTE_W-1:0]           i_s_axis_tdata,  // data_byte
    input  logic                                  i_s_axis_tuser,  // first
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // byte_value, total_frags, fragment_number, data_size, final_fragment, zero pad
    output logic [chpp_pkg::OUT_DATA_W-1:0]       o_m_axis_tdata,
    output logic [chpp_pkg::KIND_W-1:0]           o_m_axis_tuser,  // kind
    output logic                                  o_m_axis_tlast
);

    chpp_pkg::t_item in_item, stage_item;
    logic            stage_valid, core_ready;

    logic [chpp_pkg::BYTE_W-1:0] byte_value;
    logic [chpp_pkg::NUM_W-1:0]  total_frags, fragment_number;
    logic [chpp_pkg::SIZE_W-1:0] data_size;
    logic                        final_fragment;

    assign in_item.data_byte = i_s_axis_tdata;
    assign in_item.first     = i_s_axis_tuser;

    chpp_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_item  (in_item),
        .o_valid (stage_valid),
        .i_ready (core_ready),
        .o_item  (stage_item)
    );

    chpp_core u_core (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (stage_valid),
        .o_ready           (core_ready),
        .i_item            (stage_item),
        .o_valid           (o_m_axis_tvalid),
        .i_ready           (i_m_axis_tready),
        .o_kind            (o_m_axis_tuser),
        .o_byte_value      (byte_value),
        .o_total_frags     (total_frags),
        .o_fragment_number (fragment_number),
        .o_data_size       (data_size),
        .o_final_fragment  (final_fragment),
        .o_last            (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = chpp_pkg::OUT_DATA_W'({final_fragment, data_size,
                                                  fragment_number, total_frags,
                                                  byte_value});

endmodule
